// ===== sv/awir_pkg.sv =====
// Shared types, constants and helper functions of the area-weighted resize block.
package awir_pkg;

	localparam int MAX_DIM_DEF      = 64;
	localparam int MAX_CHANNELS_DEF = 4;

	localparam int DIM_W   = 7;   // size register width
	localparam int CHN_W   = 3;   // channel count register width
	localparam int POS_W   = 6;
	localparam int PIX_W   = 32;  // four 8-bit samples
	localparam int NUM_CH  = 4;
	localparam int CRD_W   = 14;  // scaled coordinate width
	localparam int TOT_W   = 14;  // sw*sh
	localparam int ACC_W   = 22;  // weighted sum plus rounding term
	localparam int Q_DEPTH = 4;
	localparam int PIX_MAX = 255;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [2:0] REG_SW  = 3'd0;
	localparam logic [2:0] REG_SH  = 3'd1;
	localparam logic [2:0] REG_DW  = 3'd2;
	localparam logic [2:0] REG_DH  = 3'd3;
	localparam logic [2:0] REG_NCH = 3'd4;

	typedef enum logic [1:0] {
		K_WRITE,
		K_READ,
		K_RERR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [PIX_W-1:0]   pix;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] dh;
		logic [CHN_W-1:0] nch;
	} cfg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SETUP,
		B_WGO,
		B_WWAIT,
		B_INIT,
		B_WALK,
		B_DRAIN,
		B_NGO,
		B_NWAIT,
		B_OUT
	} bstate_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw, input int max_v);
		logic [DIM_W-1:0] r;
		r = raw;
		if (raw == '0)
			r = DIM_W'(1);
		else if (int'(raw) > max_v)
			r = DIM_W'(max_v);
		return r;
	endfunction

	function automatic logic [CHN_W-1:0] eff_chan(input logic [CHN_W-1:0] raw, input int max_v);
		logic [CHN_W-1:0] r;
		r = raw;
		if (raw == '0)
			r = CHN_W'(1);
		else if (int'(raw) > max_v)
			r = CHN_W'(max_v);
		return r;
	endfunction

endpackage

// ===== sv/awir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module awir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/awir_front.sv =====
// Front end: accepts items, drops out-of-range writes, tags reads.
module awir_front import awir_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);
	logic [POS_W-1:0] x, y;
	logic             in_src, in_dst;

	assign x = s_tdata[5:0];
	assign y = s_tdata[11:6];
	assign in_src = ({1'b0, x} < cfg.sw) && ({1'b0, y} < cfg.sh);
	assign in_dst = ({1'b0, x} < cfg.dw) && ({1'b0, y} < cfg.dh);

	assign s_tready = !q_full;

	// Classify the item and push it unless it is a dropped write
	always_comb begin
		q_item.x    = x;
		q_item.y    = y;
		q_item.pix  = s_tdata[43:12];
		q_item.kind = K_WRITE;
		q_push      = 1'b0;
		if (s_tuser == CMD_WRITE) begin
			q_item.kind = K_WRITE;
			q_push      = s_tvalid && s_tready && in_src;
		end else begin
			q_item.kind = in_dst ? K_READ : K_RERR;
			q_push      = s_tvalid && s_tready;
		end
	end
endmodule

// ===== sv/awir_fifo.sv =====
// Short item queue between the front end and the back end.
module awir_fifo import awir_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t dout
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         ent_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= din;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== sv/awir_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module awir_div #(
	parameter int N = 22,
	parameter int D = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quotient
);
	localparam int KW = $clog2(N + 1);

	logic [D-1:0]  rem_q, dsr_q;
	logic [N-1:0]  quo_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [D:0]    trial;
	logic          fits;

	assign trial    = {rem_q, quo_q[N-1]};
	assign fits     = trial >= {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? D'(trial - {1'b0, dsr_q}) : D'(trial);
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== sv/awir_back.sv =====
// Back end: stores pixels, walks the covering window of a read and normalizes.
module awir_back import awir_pkg::*; #(
	parameter int MAX_DIM      = MAX_DIM_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tuser
);
	localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
	localparam int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	bstate_t state_q, state_d;

	logic [POS_W-1:0] x_q, y_q;
	logic [CRD_W-1:0] lo_ax_q, hi_ax_q, lo_ay_q, hi_ay_q;
	logic [CRD_W-1:0] lo_bx0_q, lo_bx_q, lo_by_q;
	logic [TOT_W-1:0] total_q;
	logic [DIM_W-1:0] sx0_q, sx1_q, sy0_q, sy1_q, sx_q, sy_q;
	logic [1:0]       op_q;
	logic [CHN_W-1:0] ch_q;
	logic [ACC_W-1:0] acc_q [MAX_CHANNELS];
	logic [7:0]       res_q [NUM_CH];

	logic [DIM_W-1:0] wx_s1, wy_s1;
	logic             v_s1, v_s2;
	logic [TOT_W-1:0] w_s2;
	logic [PIX_W-1:0] pix_s2;

	logic             out_valid_q, out_err_q;
	logic [POS_W-1:0] out_x_q, out_y_q;
	logic [7:0]       out_ch_q [NUM_CH];

	logic             out_free, out_load, out_err;
	logic             ram_we, div_start, div_done, walk_go;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [PIX_W-1:0] ram_rdata;
	logic [ACC_W-1:0] div_num, div_quo;
	logic [TOT_W-1:0] div_den;
	logic [CRD_W-1:0] hi_bx, hi_by, mnx, mxx, mny, mxy;
	logic [DIM_W-1:0] wx, wy, q_clip;
	logic             row_end, col_end;

	assign out_free = !out_valid_q || m_tready;

	// Store and window memory
	assign ram_waddr = AW'(int'(q_item.y) * MAX_DIM + int'(q_item.x));
	assign ram_raddr = AW'(int'(sy_q) * MAX_DIM + int'(sx_q));

	awir_ram #(.WIDTH(PIX_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_item.pix),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Select divider operands: window bounds first, then channel averages
	always_comb begin
		div_num = '0;
		div_den = '0;
		if (state_q == B_WGO) begin
			unique case (op_q)
				2'd0: begin div_num = ACC_W'(lo_ax_q); div_den = TOT_W'(cfg.dw); end
				2'd1: begin
					div_num = ACC_W'(hi_ax_q) + ACC_W'(cfg.dw) - 1'b1;
					div_den = TOT_W'(cfg.dw);
				end
				2'd2: begin div_num = ACC_W'(lo_ay_q); div_den = TOT_W'(cfg.dh); end
				2'd3: begin
					div_num = ACC_W'(hi_ay_q) + ACC_W'(cfg.dh) - 1'b1;
					div_den = TOT_W'(cfg.dh);
				end
			endcase
		end else begin
			div_num = acc_q[ch_q[CH_IW-1:0]] + ACC_W'(total_q >> 1);
			div_den = total_q;
		end
	end

	awir_div #(.N(ACC_W), .D(TOT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Overlap of the current source cell with the destination cell
	assign hi_bx = lo_bx_q + CRD_W'(cfg.dw);
	assign hi_by = lo_by_q + CRD_W'(cfg.dh);
	assign mnx   = (hi_ax_q < hi_bx) ? hi_ax_q : hi_bx;
	assign mxx   = (lo_ax_q > lo_bx_q) ? lo_ax_q : lo_bx_q;
	assign mny   = (hi_ay_q < hi_by) ? hi_ay_q : hi_by;
	assign mxy   = (lo_ay_q > lo_by_q) ? lo_ay_q : lo_by_q;
	assign wx    = (mnx > mxx) ? DIM_W'(mnx - mxx) : '0;
	assign wy    = (mny > mxy) ? DIM_W'(mny - mxy) : '0;
	assign col_end = (sx_q + 1'b1 == sx1_q);
	assign row_end = (sy_q + 1'b1 == sy1_q);

	// Upper window bounds clip to the source size
	always_comb begin
		q_clip = DIM_W'(div_quo);
		if (op_q == 2'd1 && div_quo > ACC_W'(cfg.sw))
			q_clip = cfg.sw;
		else if (op_q == 2'd3 && div_quo > ACC_W'(cfg.sh))
			q_clip = cfg.sh;
	end

	// Next state and control strobes
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		out_err   = 1'b0;
		walk_go   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					unique case (q_item.kind)
						K_WRITE: begin
							ram_we = 1'b1;
							q_pop  = 1'b1;
						end
						K_READ: begin
							q_pop   = 1'b1;
							state_d = B_SETUP;
						end
						K_RERR: begin
							if (out_free) begin
								out_load = 1'b1;
								out_err  = 1'b1;
								q_pop    = 1'b1;
							end
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			B_SETUP: state_d = B_WGO;
			B_WGO: begin
				div_start = 1'b1;
				state_d   = B_WWAIT;
			end
			B_WWAIT: begin
				if (div_done)
					state_d = (op_q == 2'd3) ? B_INIT : B_WGO;
			end
			B_INIT: state_d = B_WALK;
			B_WALK: begin
				walk_go = 1'b1;
				if (col_end && row_end)
					state_d = B_DRAIN;
			end
			B_DRAIN: begin
				if (!v_s1 && !v_s2)
					state_d = B_NGO;
			end
			B_NGO: begin
				if (ch_q < cfg.nch) begin
					div_start = 1'b1;
					state_d   = B_NWAIT;
				end else begin
					state_d = B_OUT;
				end
			end
			B_NWAIT: begin
				if (div_done)
					state_d = B_NGO;
			end
			B_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	// Read setup, window bounds and walk counters
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_pop) begin
			x_q <= q_item.x;
			y_q <= q_item.y;
		end
		if (state_q == B_SETUP) begin
			lo_ax_q <= CRD_W'(x_q) * CRD_W'(cfg.sw);
			hi_ax_q <= (CRD_W'(x_q) + 1'b1) * CRD_W'(cfg.sw);
			lo_ay_q <= CRD_W'(y_q) * CRD_W'(cfg.sh);
			hi_ay_q <= (CRD_W'(y_q) + 1'b1) * CRD_W'(cfg.sh);
			total_q <= TOT_W'(cfg.sw) * TOT_W'(cfg.sh);
			op_q    <= '0;
			ch_q    <= '0;
		end
		if (state_q == B_WWAIT && div_done) begin
			unique case (op_q)
				2'd0: sx0_q <= q_clip;
				2'd1: sx1_q <= q_clip;
				2'd2: sy0_q <= q_clip;
				2'd3: sy1_q <= q_clip;
			endcase
			op_q <= op_q + 1'b1;
		end
		if (state_q == B_INIT) begin
			lo_bx0_q <= CRD_W'(sx0_q) * CRD_W'(cfg.dw);
			lo_bx_q  <= CRD_W'(sx0_q) * CRD_W'(cfg.dw);
			lo_by_q  <= CRD_W'(sy0_q) * CRD_W'(cfg.dh);
			sx_q     <= sx0_q;
			sy_q     <= sy0_q;
		end
		if (walk_go) begin
			if (col_end) begin
				sx_q    <= sx0_q;
				lo_bx_q <= lo_bx0_q;
				sy_q    <= sy_q + 1'b1;
				lo_by_q <= lo_by_q + CRD_W'(cfg.dh);
			end else begin
				sx_q    <= sx_q + 1'b1;
				lo_bx_q <= lo_bx_q + CRD_W'(cfg.dw);
			end
		end
		if (state_q == B_NWAIT && div_done) begin
			res_q[ch_q[1:0]] <= (div_quo > ACC_W'(PIX_MAX)) ? 8'(PIX_MAX) : div_quo[7:0];
			ch_q <= ch_q + 1'b1;
		end
		if (state_q == B_SETUP) begin
			for (int c = 0; c < NUM_CH; c++)
				res_q[c] <= '0;
		end
	end

	// Weight and accumulate pipeline
	always_ff @(posedge clk) begin
		wx_s1  <= wx;
		wy_s1  <= wy;
		w_s2   <= TOT_W'(wy_s1) * TOT_W'(wx_s1);
		pix_s2 <= ram_rdata;
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			if (state_q == B_SETUP)
				acc_q[c] <= '0;
			else if (v_s2 && CHN_W'(c) < cfg.nch)
				acc_q[c] <= acc_q[c] + ACC_W'(w_s2) * ACC_W'(pix_s2[8*c +: 8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= walk_go;
			v_s2 <= v_s1;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_err_q <= out_err;
			if (out_err) begin
				out_x_q <= q_item.x;
				out_y_q <= q_item.y;
				for (int c = 0; c < NUM_CH; c++)
					out_ch_q[c] <= '0;
			end else begin
				out_x_q <= x_q;
				out_y_q <= y_q;
				for (int c = 0; c < NUM_CH; c++)
					out_ch_q[c] <= res_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_err_q;
	assign m_tdata  = {4'b0, out_ch_q[3], out_ch_q[2], out_ch_q[1], out_ch_q[0],
		out_y_q, out_x_q};
endmodule

// ===== sv/area_weighted_image_resize.sv =====
// Area-weighted resize top level: register port, front end, queue and back end.
// A pixel write is stored by the back end from its idle state; items enter the queue at one
// per cycle while the queue is not full. A read's time is set by the shared bit-serial
// divider, which finds the window bounds and then each used channel's average, and by
// the one-pixel-per-cycle frame store port that walks the covered source window.
// Reset clears control state and loads the size registers with their defaults.
module area_weighted_image_resize import awir_pkg::*; #(
	parameter int MAX_DIM      = MAX_DIM_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pos_x, pos_y, in_chan0..in_chan3, zero pad
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_x, out_y, out_chan0..out_chan3, zero pad
	output logic        m_tuser,   // range_error
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
	logic [CHN_W-1:0] nch_q;
	cfg_t             cfg;
	logic             wr_en;
	logic             q_push, q_full, q_pop, q_valid;
	item_t            q_in, q_out;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q  <= DIM_W'(64);
			sh_q  <= DIM_W'(64);
			dw_q  <= DIM_W'(32);
			dh_q  <= DIM_W'(32);
			nch_q <= CHN_W'(1);
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_SW:  sw_q  <= pwdata[DIM_W-1:0];
				REG_SH:  sh_q  <= pwdata[DIM_W-1:0];
				REG_DW:  dw_q  <= pwdata[DIM_W-1:0];
				REG_DH:  dh_q  <= pwdata[DIM_W-1:0];
				REG_NCH: nch_q <= pwdata[CHN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back registers
	always_comb begin
		unique case (paddr[4:2])
			REG_SW:  prdata = 32'(sw_q);
			REG_SH:  prdata = 32'(sh_q);
			REG_DW:  prdata = 32'(dw_q);
			REG_DH:  prdata = 32'(dh_q);
			REG_NCH: prdata = 32'(nch_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.sw  = eff_dim(sw_q, MAX_DIM);
	assign cfg.sh  = eff_dim(sh_q, MAX_DIM);
	assign cfg.dw  = eff_dim(dw_q, MAX_DIM);
	assign cfg.dh  = eff_dim(dh_q, MAX_DIM);
	assign cfg.nch = eff_chan(nch_q, MAX_CHANNELS);

	awir_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	awir_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.dout      (q_out)
	);

	awir_back #(.MAX_DIM(MAX_DIM), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule

// ===== sv/awir_checker.sv =====
// Port-level checks of the resize block, bound to the top level.
module awir_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);
	// A stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An out-of-range read carries zero channels
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[43:12] == 32'd0)
		else $error("range error with nonzero channels");

	// No result comes out of reset
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result valid at reset release");
endmodule

bind area_weighted_image_resize awir_port_checks u_chk (.*);

// ===== sim/awir_checker.sv =====
// Stream and register monitor with pixel prediction and result comparison for the resize block.
module awir_checker import awir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // pos_x, pos_y, in_chan0..in_chan3, zero pad
	input  logic        s_tuser,   // cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // out_x, out_y, out_chan0..out_chan3, zero pad
	input  logic        m_tuser,   // range_error
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          pending,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		int x;
		int y;
		int chan[4];
		bit range_err;
	} pixel_out_t;

	logic [31:0] frame_store [MAX_DIM_DEF*MAX_DIM_DEF];
	pixel_out_t  expected_pixels [$];
	int          raw_sw, raw_sh, raw_dw, raw_dh, raw_nch;

	function automatic int clip_dim(int v);
		return (v < 1) ? 1 : (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
	endfunction

	// Overlap of destination cell d (pitch s) with source cell k (pitch t).
	function automatic int span_overlap(int d, int k, int s, int t);
		int hi, lo;
		hi = ((d + 1) * s < (k + 1) * t) ? (d + 1) * s : (k + 1) * t;
		lo = (d * s > k * t) ? d * s : k * t;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// Compute one destination pixel from the current frame and sizes.
	function automatic pixel_out_t predict_pixel(int x, int y);
		pixel_out_t r;
		int sw, sh, dw, dh, nch, total, sx0, sx1, sy0, sy1, wy, w;
		longint acc [4];
		longint v;
		sw = clip_dim(raw_sw);
		sh = clip_dim(raw_sh);
		dw = clip_dim(raw_dw);
		dh = clip_dim(raw_dh);
		nch = (raw_nch < 1) ? 1 : (raw_nch > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : raw_nch;
		r.x = x;
		r.y = y;
		r.range_err = 0;
		for (int c = 0; c < 4; c++) begin
			r.chan[c] = 0;
			acc[c] = 0;
		end
		if (x >= dw || y >= dh) begin
			r.range_err = 1;
			return r;
		end
		total = sw * sh;
		sx0 = x * sw / dw;
		sx1 = ((x + 1) * sw + dw - 1) / dw;
		sy0 = y * sh / dh;
		sy1 = ((y + 1) * sh + dh - 1) / dh;
		if (sx1 > sw) sx1 = sw;
		if (sy1 > sh) sy1 = sh;
		for (int sy = sy0; sy < sy1; sy++) begin
			wy = span_overlap(y, sy, sh, dh);
			for (int sx = sx0; sx < sx1; sx++) begin
				w = wy * span_overlap(x, sx, sw, dw);
				for (int c = 0; c < nch; c++)
					acc[c] += longint'(w) * frame_store[sy*MAX_DIM_DEF + sx][8*c +: 8];
			end
		end
		for (int c = 0; c < nch; c++) begin
			v = (acc[c] + total / 2) / total;
			r.chan[c] = (v > PIX_MAX) ? PIX_MAX : int'(v);
		end
		return r;
	endfunction

	// Track registers, store writes, predict reads, compare results.
	always @(posedge clk or negedge arst_n) begin
		pixel_out_t e;
		int ax, ay;
		int got [4];
		if (!arst_n) begin
			raw_sw = 64;
			raw_sh = 64;
			raw_dw = 32;
			raw_dh = 32;
			raw_nch = 1;
			failures <= 0;
			expected_pixels.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_SW:  raw_sw = pwdata[6:0];
					REG_SH:  raw_sh = pwdata[6:0];
					REG_DW:  raw_dw = pwdata[6:0];
					REG_DH:  raw_dh = pwdata[6:0];
					REG_NCH: raw_nch = pwdata[2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				ax = s_tdata[5:0];
				ay = s_tdata[11:6];
				if (s_tuser == CMD_WRITE) begin
					if (ax < clip_dim(raw_sw) && ay < clip_dim(raw_sh))
						frame_store[ay*MAX_DIM_DEF + ax] = s_tdata[43:12];
				end else
					expected_pixels.push_back(predict_pixel(ax, ay));
			end
			if (m_tvalid && m_tready) begin
				for (int c = 0; c < 4; c++)
					got[c] = m_tdata[12 + 8*c +: 8];
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d", $realtime,
						m_tdata[5:0], m_tdata[11:6]);
					failures <= failures + 1;
				end else begin
					e = expected_pixels.pop_front();
					if (e.x != m_tdata[5:0] || e.y != m_tdata[11:6] ||
						e.range_err != m_tuser || e.chan != got) begin
						$display("%0t: mismatch exp x=%0d y=%0d ch=%p err=%0d",
							$realtime, e.x, e.y, e.chan, e.range_err);
						$display("%0t:          act x=%0d y=%0d ch=%p err=%0d",
							$realtime, m_tdata[5:0], m_tdata[11:6], got, m_tuser);
						failures <= failures + 1;
					end
				end
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the resize block test: clock, reset, stimulus phases and verdict.
module testbench;
	import awir_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // pos_x, pos_y, in_chan0..in_chan3, zero pad
	logic        s_tuser = 0;    // cmd
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;        // out_x, out_y, out_chan0..out_chan3, zero pad
	logic        m_tuser;        // range_error
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          pending;
	int          failures;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          cur_sw = 64, cur_sh = 64, cur_dw = 32, cur_dh = 32;

	area_weighted_image_resize uut (.*);

	awir_checker pixel_check (.*);

	always #6 clk = ~clk;

	// Stall the result side at the phase's rate.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	initial begin
		#50_000_000;
		$display("[area_weighted_image_resize] ERROR");
		$finish;
	end

	function automatic int clip_dim(int v);
		return (v < 1) ? 1 : (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
	endfunction

	// Offer one item, with random idle gaps before it; valid stays high after.
	task automatic push_item(logic cmd, int x, int y, logic [31:0] pix);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, pix, 6'(y), 6'(x)};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and hold until every result is back, then let the block settle.
	task automatic drain;
		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, int val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= (32'($urandom) & ~32'h7F) | 32'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	task automatic configure(int sw, int sh, int dw, int dh, int nch);
		reg_write(REG_SW, sw);
		reg_write(REG_SH, sh);
		reg_write(REG_DW, dw);
		reg_write(REG_DH, dh);
		reg_write(REG_NCH, nch);
		cur_sw = clip_dim(sw);
		cur_sh = clip_dim(sh);
		cur_dw = clip_dim(dw);
		cur_dh = clip_dim(dh);
	endtask

	// Mixed random writes and reads, mostly in range.
	task automatic random_items(int n);
		int x, y;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 25) begin
				x = ($urandom_range(99) < 85) ? $urandom_range(cur_sw - 1) : $urandom_range(63);
				y = ($urandom_range(99) < 85) ? $urandom_range(cur_sh - 1) : $urandom_range(63);
				push_item(CMD_WRITE, x, y, $urandom);
			end else begin
				x = ($urandom_range(99) < 90) ? $urandom_range(cur_dw - 1) : $urandom_range(63);
				y = ($urandom_range(99) < 90) ? $urandom_range(cur_dh - 1) : $urandom_range(63);
				push_item(CMD_READ, x, y, $urandom);
			end
		end
	endtask

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 29; recv_stall_pct = 29; end
		endcase
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill the whole frame under reset sizes so no read touches an unwritten pixel.
		push_item(CMD_WRITE, 0, 0, 32'h0);
		push_item(CMD_WRITE, 63, 63, 32'hFFFF_FFFF);
		for (int y = 0; y < 64; y++)
			for (int x = 0; x < 64; x++)
				if (!((x == 0 && y == 0) || (x == 63 && y == 63)))
					push_item(CMD_WRITE, x, y, $urandom);
		push_item(CMD_READ, 0, 0, 0);
		push_item(CMD_READ, 31, 31, 0);
		push_item(CMD_READ, 32, 5, 0);
		random_items(40);
		drain();

		// Small odd sizes, channel count zero: out-of-range writes and reads.
		set_idling(1);
		configure(5, 3, 7, 2, 0);
		push_item(CMD_WRITE, 5, 0, 32'hFFFF_FFFF);
		push_item(CMD_WRITE, 0, 3, 32'hFFFF_FFFF);
		push_item(CMD_WRITE, 4, 2, 32'hFFFF_FFFF);
		push_item(CMD_READ, 0, 0, 0);
		push_item(CMD_READ, 6, 1, 0);
		push_item(CMD_READ, 7, 0, 0);
		push_item(CMD_READ, 0, 2, 0);
		push_item(CMD_READ, 63, 63, 0);
		drain();

		// Same size: plain copy, all four channels.
		set_idling(2);
		configure(64, 64, 64, 64, 4);
		random_items(60);
		drain();

		// Full frame down to one pixel, channel count above range.
		set_idling(3);
		configure(64, 64, 1, 1, 7);
		push_item(CMD_READ, 0, 0, 0);
		push_item(CMD_READ, 1, 0, 0);
		push_item(CMD_READ, 0, 0, 0);
		drain();

		// Size registers at zero and above range.
		set_idling(0);
		configure(0, 127, 127, 0, 3);
		random_items(60);
		drain();

		// One pixel up to full size.
		configure(1, 1, 64, 64, 2);
		random_items(40);
		drain();

		// Random sizes, mostly small sources.
		for (int p = 0; p < 12; p++) begin
			set_idling(p);
			if ($urandom_range(3) == 0)
				configure($urandom_range(1, 64), $urandom_range(1, 64),
					$urandom_range(16, 64), $urandom_range(16, 64), $urandom_range(7));
			else
				configure($urandom_range(1, 16), $urandom_range(1, 16),
					$urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(7));
			random_items(170);
			drain();
		end

		repeat (500) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("[area_weighted_image_resize] OK");
		else
			$display("[area_weighted_image_resize] ERROR");
		$finish;
	end

endmodule
